// File: rtl/core/bas_pkg.sv
// Shared types and constants for the byte ALU.
package bas_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned OP_W            = 5;
  localparam int unsigned DIV_STAGES      = 4;
  localparam int unsigned STEPS_PER_STAGE = 2;  // DIV_STAGES * STEPS_PER_STAGE == DATA_W

  typedef enum logic [OP_W-1:0] {
    OP_SADD, OP_SSUB, OP_SMUL, OP_SDIV, OP_SMOD, OP_SINC, OP_SDEC,
    OP_UADD, OP_USUB, OP_UMUL, OP_UDIV, OP_UMOD, OP_UINC, OP_UDEC,
    OP_AND,  OP_OR,   OP_XOR,  OP_XNOR, OP_NAND, OP_NOT,
    OP_SEQ,  OP_SNE,  OP_SGT,  OP_SLT,  OP_SGE,  OP_SLE,
    OP_UEQ,  OP_UNE,  OP_UGT,  OP_ULT,  OP_UGE,  OP_ULE
  } op_t;

  typedef enum logic [4:0] {
    K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_INC, K_DEC,
    K_AND, K_OR, K_XOR, K_XNOR, K_NAND, K_NOT,
    K_EQ, K_NE, K_GT, K_LT, K_GE, K_LE
  } kind_t;

  // Decoded item as it sits in the queue.
  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] a;      // msb flipped for signed compares
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] a_mag;  // divider magnitudes
    logic [DATA_W-1:0] b_mag;
    logic              q_neg;
    logic              r_neg;
  } dec_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    dec_t item;
  } qhead_t;

endpackage

// File: rtl/core/bas_front.sv
// Front end: takes input beats and decodes the opcode for the queue.
module bas_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bas_pkg::OP_W-1:0]    in_op,
  input  logic [bas_pkg::DATA_W-1:0]  in_operand_a,
  input  logic [bas_pkg::DATA_W-1:0]  in_operand_b,
  input  logic                        q_full,
  output logic                        q_wr,
  output bas_pkg::dec_t               q_item
);

  bas_pkg::kind_t            kind;
  logic                      sgn;
  logic                      is_cmp;
  logic                      flip;
  logic                      a_neg;
  logic                      b_neg;
  logic [bas_pkg::DATA_W-1:0] msb;

  assign msb = {1'b1, {(bas_pkg::DATA_W-1){1'b0}}};

  always_comb begin
    sgn  = 1'b0;
    kind = bas_pkg::K_ADD;
    unique case (bas_pkg::op_t'(in_op))
      bas_pkg::OP_SADD: begin kind = bas_pkg::K_ADD;  sgn = 1'b1; end
      bas_pkg::OP_SSUB: begin kind = bas_pkg::K_SUB;  sgn = 1'b1; end
      bas_pkg::OP_SMUL: begin kind = bas_pkg::K_MUL;  sgn = 1'b1; end
      bas_pkg::OP_SDIV: begin kind = bas_pkg::K_DIV;  sgn = 1'b1; end
      bas_pkg::OP_SMOD: begin kind = bas_pkg::K_MOD;  sgn = 1'b1; end
      bas_pkg::OP_SINC: begin kind = bas_pkg::K_INC;  sgn = 1'b1; end
      bas_pkg::OP_SDEC: begin kind = bas_pkg::K_DEC;  sgn = 1'b1; end
      bas_pkg::OP_UADD: kind = bas_pkg::K_ADD;
      bas_pkg::OP_USUB: kind = bas_pkg::K_SUB;
      bas_pkg::OP_UMUL: kind = bas_pkg::K_MUL;
      bas_pkg::OP_UDIV: kind = bas_pkg::K_DIV;
      bas_pkg::OP_UMOD: kind = bas_pkg::K_MOD;
      bas_pkg::OP_UINC: kind = bas_pkg::K_INC;
      bas_pkg::OP_UDEC: kind = bas_pkg::K_DEC;
      bas_pkg::OP_AND:  kind = bas_pkg::K_AND;
      bas_pkg::OP_OR:   kind = bas_pkg::K_OR;
      bas_pkg::OP_XOR:  kind = bas_pkg::K_XOR;
      bas_pkg::OP_XNOR: kind = bas_pkg::K_XNOR;
      bas_pkg::OP_NAND: kind = bas_pkg::K_NAND;
      bas_pkg::OP_NOT:  kind = bas_pkg::K_NOT;
      bas_pkg::OP_SEQ:  begin kind = bas_pkg::K_EQ; sgn = 1'b1; end
      bas_pkg::OP_SNE:  begin kind = bas_pkg::K_NE; sgn = 1'b1; end
      bas_pkg::OP_SGT:  begin kind = bas_pkg::K_GT; sgn = 1'b1; end
      bas_pkg::OP_SLT:  begin kind = bas_pkg::K_LT; sgn = 1'b1; end
      bas_pkg::OP_SGE:  begin kind = bas_pkg::K_GE; sgn = 1'b1; end
      bas_pkg::OP_SLE:  begin kind = bas_pkg::K_LE; sgn = 1'b1; end
      bas_pkg::OP_UEQ:  kind = bas_pkg::K_EQ;
      bas_pkg::OP_UNE:  kind = bas_pkg::K_NE;
      bas_pkg::OP_UGT:  kind = bas_pkg::K_GT;
      bas_pkg::OP_ULT:  kind = bas_pkg::K_LT;
      bas_pkg::OP_UGE:  kind = bas_pkg::K_GE;
      bas_pkg::OP_ULE:  kind = bas_pkg::K_LE;
      default:          kind = bas_pkg::K_ADD;
    endcase
  end

  assign is_cmp = (kind == bas_pkg::K_EQ) || (kind == bas_pkg::K_NE) ||
                  (kind == bas_pkg::K_GT) || (kind == bas_pkg::K_LT) ||
                  (kind == bas_pkg::K_GE) || (kind == bas_pkg::K_LE);
  // signed compare == unsigned compare with both sign bits inverted
  assign flip   = sgn && is_cmp;
  assign a_neg  = sgn && in_operand_a[bas_pkg::DATA_W-1];
  assign b_neg  = sgn && in_operand_b[bas_pkg::DATA_W-1];

  always_comb begin
    q_item.kind  = kind;
    q_item.a     = flip ? (in_operand_a ^ msb) : in_operand_a;
    q_item.b     = flip ? (in_operand_b ^ msb) : in_operand_b;
    q_item.a_mag = a_neg ? (~in_operand_a + 1'b1) : in_operand_a;
    q_item.b_mag = b_neg ? (~in_operand_b + 1'b1) : in_operand_b;
    q_item.q_neg = a_neg ^ b_neg;
    q_item.r_neg = a_neg;
  end

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;

endmodule

// File: rtl/core/bas_queue.sv
// Small decoupling queue between front and back end.
module bas_queue #(
  parameter int unsigned DEPTH = 2  // 2..16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  bas_pkg::dec_t   wr_item,
  output logic            full,
  output bas_pkg::qhead_t head,
  input  logic            pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bas_pkg::dec_t   mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({wr, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: rtl/core/bas_back.sv
// Back end: ALU stage, pipelined restoring divider and output register.
module bas_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bas_pkg::qhead_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bas_pkg::DATA_W-1:0]  out_result,
  output logic                        out_div_by_zero
);

  localparam int unsigned W = bas_pkg::DATA_W;
  localparam int unsigned S = bas_pkg::DIV_STAGES;

  typedef struct packed {
    logic           valid;
    bas_pkg::kind_t kind;
    logic [W-1:0]   fast;
    logic [W-1:0]   rem;
    logic [W-1:0]   quo;   // dividend shifts out, quotient shifts in
    logic [W-1:0]   den;
    logic           q_neg;
    logic           r_neg;
  } stg_t;

  stg_t          stage_r [S];
  stg_t          stage_nxt [S];
  logic          adv;
  logic [2*W-1:0] prod;
  logic [W-1:0]  fast;
  logic          out_valid_r;
  logic [W-1:0]  out_result_r, out_result_nxt;
  logic          out_dz_r, out_dz_nxt;
  stg_t          last;
  logic          is_div;

  // one restoring step: remainder/dividend pair shifted one bit
  function automatic stg_t div_step(input stg_t s);
    logic [W:0]   shifted;
    logic [W+1:0] diff;
    logic         ge;
    stg_t         r;
    r       = s;
    shifted = {s.rem, s.quo[W-1]};
    diff    = {1'b0, shifted} - {2'b00, s.den};
    ge      = !diff[W+1];
    r.rem   = ge ? diff[W-1:0] : shifted[W-1:0];
    r.quo   = {s.quo[W-2:0], ge};
    return r;
  endfunction

  assign adv = !out_valid_r || !out_stall;
  assign pop = head.valid && adv;
  assign prod = head.item.a * head.item.b;

  always_comb begin
    unique case (head.item.kind)
      bas_pkg::K_ADD:  fast = head.item.a + head.item.b;
      bas_pkg::K_SUB:  fast = head.item.a - head.item.b;
      bas_pkg::K_MUL:  fast = prod[W-1:0];
      bas_pkg::K_INC:  fast = head.item.a + 1'b1;
      bas_pkg::K_DEC:  fast = head.item.a - 1'b1;
      bas_pkg::K_AND:  fast = head.item.a & head.item.b;
      bas_pkg::K_OR:   fast = head.item.a | head.item.b;
      bas_pkg::K_XOR:  fast = head.item.a ^ head.item.b;
      bas_pkg::K_XNOR: fast = ~(head.item.a ^ head.item.b);
      bas_pkg::K_NAND: fast = ~(head.item.a & head.item.b);
      bas_pkg::K_NOT:  fast = ~head.item.a;
      bas_pkg::K_EQ:   fast = W'(head.item.a == head.item.b);
      bas_pkg::K_NE:   fast = W'(head.item.a != head.item.b);
      bas_pkg::K_GT:   fast = W'(head.item.a >  head.item.b);
      bas_pkg::K_LT:   fast = W'(head.item.a <  head.item.b);
      bas_pkg::K_GE:   fast = W'(head.item.a >= head.item.b);
      bas_pkg::K_LE:   fast = W'(head.item.a <= head.item.b);
      default:         fast = '0;  // div and mod come from the divider
    endcase
  end

  always_comb begin
    stg_t s;
    s.valid = head.valid;
    s.kind  = head.item.kind;
    s.fast  = fast;
    s.rem   = '0;
    s.quo   = head.item.a_mag;
    s.den   = head.item.b_mag;
    s.q_neg = head.item.q_neg;
    s.r_neg = head.item.r_neg;
    for (int k = 0; k < S; k++) begin
      if (k != 0) begin
        s = stage_r[k-1];
      end
      for (int j = 0; j < bas_pkg::STEPS_PER_STAGE; j++) begin
        s = div_step(s);
      end
      stage_nxt[k] = s;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < S; k++) begin
      if (!rst_n) begin
        stage_r[k].valid <= 1'b0;
      end else if (adv) begin
        stage_r[k] <= stage_nxt[k];
      end
    end
  end

  assign last   = stage_r[S-1];
  assign is_div = (last.kind == bas_pkg::K_DIV) || (last.kind == bas_pkg::K_MOD);

  always_comb begin
    out_dz_nxt     = 1'b0;
    out_result_nxt = last.fast;
    if (is_div) begin
      if (last.den == '0) begin
        out_dz_nxt     = 1'b1;
        out_result_nxt = '0;
      end else if (last.kind == bas_pkg::K_DIV) begin
        out_result_nxt = last.q_neg ? (~last.quo + 1'b1) : last.quo;
      end else begin
        out_result_nxt = last.r_neg ? (~last.rem + 1'b1) : last.rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= out_result_nxt;
      out_dz_r     <= out_dz_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_div_by_zero = out_dz_r;

endmodule

// File: rtl/core/byte_alu_signed_unsigned_top.sv
// Top level of the byte ALU: front decode, queue, back-end pipeline.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in_     | input     | in_valid / in_stall | in_op, in_operand_a, in_operand_b
//  out_    | output    | out_valid/out_stall | out_result, out_div_by_zero
//
//  One beat per cycle sustained, in and out, while out_stall stays low; no beat
//  depends on an earlier one. A taken beat is written to the queue, enters the
//  back end when popped, walks the four divider stages (two quotient bits each)
//  and is then captured in the output register, which raises out_valid.
//  Every beat uses the same path, so results leave in input order.
//  rst_n is synchronous; it empties the queue and clears all valid bits.
//  out_stall freezes the whole back end while out_valid is high; the queue then fills and raises in_stall.
module byte_alu_signed_unsigned_top #(
  parameter int unsigned QUEUE_DEPTH = 2  // 2..16 entries
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bas_pkg::OP_W-1:0]    in_op,
  input  logic [bas_pkg::DATA_W-1:0]  in_operand_a,
  input  logic [bas_pkg::DATA_W-1:0]  in_operand_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bas_pkg::DATA_W-1:0]  out_result,
  output logic                        out_div_by_zero
);

  logic            q_full;
  logic            q_wr;
  logic            q_pop;
  bas_pkg::dec_t   q_item;
  bas_pkg::qhead_t q_head;

  // decode; stalls only on a full queue
  bas_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_item       (q_item)
  );

  bas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_item),
    .full    (q_full),
    .head    (q_head),
    .pop     (q_pop)
  );

  // execution pipeline; advances whenever the output register can move
  bas_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result      (out_result),
    .out_div_by_zero (out_div_by_zero)
  );

  // a divide-by-zero beat always carries a zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> (out_result == '0))
    else $error("div_by_zero beat with nonzero result");

  // a full queue must have a head entry
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_head.valid)
    else $error("queue full but head empty");

  // back end drains the queue whenever it is not blocked downstream
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_head.valid && !(out_valid && out_stall)) |-> q_pop)
    else $error("queue head not taken by idle back end");

  // nothing is popped from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("pop from empty queue");

endmodule
